>>> design/cpbe_pkg.sv
// ----------------------------------------------------------------------------
// cpbe_pkg
// Shared types and constants of the clipped palette blit engine.
// ----------------------------------------------------------------------------
package cpbe_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_COPY  = 2'd2,
    ACT_REMAP = 2'd3
  } action_e;

  localparam logic CFG_WORLD_W = 1'b0;
  localparam logic CFG_WORLD_H = 1'b1;

  localparam logic [7:0] HI_MASK = 8'hf0;
  localparam logic [7:0] LO_MASK = 8'h0f;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP1,
    ST_CLIP2,
    ST_POINT,
    ST_PRD,
    ST_SRD,
    ST_SWAIT,
    ST_DRD,
    ST_DWAIT,
    ST_WR,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic clip_src;  // clip source / remap rectangle
    logic clip_dst;  // clip copy destination rectangle
    logic point;     // point read and write
    logic rd_src;    // issue read at source cursor
    logic rd_dst;    // issue read at destination cursor
    logic wr;        // write computed pixel, advance cursor
    logic done;      // emit result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic reject;
    logic is_copy;
    logic is_point;
    logic last;      // cursor at last pixel
  } sts_t;

endpackage

>>> design/clipped_palette_blit_engine.sv
// ----------------------------------------------------------------------------
// clipped_palette_blit_engine
// 8-bit indexed frame store with point access, keyed palette-shift copy and
// color-range remap, all clipped to the configured world.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             action_i .. pixel_in_i
// result    out        result_valid_o (1 cycle)  status_o .. done_height_o
// config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// Each pixel is a read-modify-write on the frame store (copy reads
// source and destination separately).
// Reset clears control and world registers (640 x 480); the store is not
// cleared. The receiver cannot stall: results are strobed for one cycle.
// ----------------------------------------------------------------------------
module clipped_palette_blit_engine #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [10:0]        cfg_data_i,
  input  logic [1:0]         action_i,
  input  logic signed [11:0] src_x_i,
  input  logic signed [11:0] src_y_i,
  input  logic signed [11:0] width_i,
  input  logic signed [11:0] height_i,
  input  logic signed [11:0] dst_x_i,
  input  logic signed [11:0] dst_y_i,
  input  logic [7:0]         key_color_i,
  input  logic [7:0]         range_start_i,
  input  logic [8:0]         range_count_i,
  input  logic [7:0]         remap_to_i,
  input  logic [7:0]         pixel_in_i,
  output logic               result_valid_o,
  output logic               status_o,
  output logic [7:0]         pixel_value_o,
  output logic [10:0]        done_width_o,
  output logic [10:0]        done_height_o
);

  cpbe_pkg::ctl_t ctl;
  cpbe_pkg::sts_t sts;

  // sequencer
  cpbe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // clip, cursors and frame store
  cpbe_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i, .rst_ni,
    .ctl_i(ctl), .sts_o(sts),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .action_i, .src_x_i, .src_y_i, .width_i, .height_i, .dst_x_i, .dst_y_i,
    .key_color_i, .range_start_i, .range_count_i, .remap_to_i, .pixel_in_i,
    .result_valid_o, .status_o, .pixel_value_o, .done_width_o, .done_height_o
  );

  // a request that is taken always leaves busy high next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

  // a result ends the command
  a_result_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("result while busy");

  // a rejected command reports no size
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> done_width_o == 11'd0 && done_height_o == 11'd0)
    else $error("rejected with size");

endmodule

>>> design/cpbe_ctrl.sv
// ----------------------------------------------------------------------------
// cpbe_ctrl
// Command sequencer: clip, then one read-modify-write per pixel.
// ----------------------------------------------------------------------------
module cpbe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  cpbe_pkg::sts_t  sts_i,
  output cpbe_pkg::ctl_t  ctl_o
);

  cpbe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= cpbe_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpbe_pkg::ST_IDLE:  if (start_i) state_d = cpbe_pkg::ST_CLIP1;
      cpbe_pkg::ST_CLIP1: state_d = cpbe_pkg::ST_CLIP2;
      cpbe_pkg::ST_CLIP2: begin
        if (sts_i.reject)        state_d = cpbe_pkg::ST_DONE;
        else if (sts_i.is_point) state_d = cpbe_pkg::ST_POINT;
        else                     state_d = cpbe_pkg::ST_SRD;
      end
      cpbe_pkg::ST_POINT: state_d = cpbe_pkg::ST_PRD;
      cpbe_pkg::ST_PRD:   state_d = cpbe_pkg::ST_DONE;
      cpbe_pkg::ST_SRD:   state_d = cpbe_pkg::ST_SWAIT;
      cpbe_pkg::ST_SWAIT: state_d = sts_i.is_copy ? cpbe_pkg::ST_DRD : cpbe_pkg::ST_WR;
      cpbe_pkg::ST_DRD:   state_d = cpbe_pkg::ST_DWAIT;
      cpbe_pkg::ST_DWAIT: state_d = cpbe_pkg::ST_WR;
      cpbe_pkg::ST_WR:    state_d = sts_i.last ? cpbe_pkg::ST_DONE : cpbe_pkg::ST_SRD;
      cpbe_pkg::ST_DONE:  state_d = cpbe_pkg::ST_IDLE;
      default:            state_d = cpbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    busy_o = (state_q != cpbe_pkg::ST_IDLE);
    unique case (state_q)
      cpbe_pkg::ST_IDLE:  ctl_o.load     = start_i;
      cpbe_pkg::ST_CLIP1: ctl_o.clip_src = 1'b1;
      cpbe_pkg::ST_CLIP2: ctl_o.clip_dst = 1'b1;
      cpbe_pkg::ST_POINT: ctl_o.point    = 1'b1;
      cpbe_pkg::ST_SRD:   ctl_o.rd_src   = 1'b1;
      cpbe_pkg::ST_DRD:   ctl_o.rd_dst   = 1'b1;
      cpbe_pkg::ST_WR:    ctl_o.wr       = 1'b1;
      cpbe_pkg::ST_DONE:  ctl_o.done     = 1'b1;
      default:            ctl_o          = '0;
    endcase
  end

endmodule

>>> design/cpbe_datapath.sv
// ----------------------------------------------------------------------------
// cpbe_datapath
// Clip arithmetic, pixel cursors, frame store and result register.
// ----------------------------------------------------------------------------
module cpbe_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cpbe_pkg::ctl_t         ctl_i,
  output cpbe_pkg::sts_t         sts_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [10:0]            cfg_data_i,
  input  logic [1:0]             action_i,
  input  logic signed [11:0]     src_x_i,
  input  logic signed [11:0]     src_y_i,
  input  logic signed [11:0]     width_i,
  input  logic signed [11:0]     height_i,
  input  logic signed [11:0]     dst_x_i,
  input  logic signed [11:0]     dst_y_i,
  input  logic [7:0]             key_color_i,
  input  logic [7:0]             range_start_i,
  input  logic [8:0]             range_count_i,
  input  logic [7:0]             remap_to_i,
  input  logic [7:0]             pixel_in_i,
  output logic                   result_valid_o,
  output logic                   status_o,
  output logic [7:0]             pixel_value_o,
  output logic [10:0]            done_width_o,
  output logic [10:0]            done_height_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int CW = 14;  // signed clip arithmetic width

  // configuration
  logic [10:0] world_w_q, world_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_w_q <= 11'd640;
      world_h_q <= 11'd480;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cpbe_pkg::CFG_WORLD_W) world_w_q <= cfg_data_i;
      else                                       world_h_q <= cfg_data_i;
    end
  end

  logic signed [CW-1:0] eff_w, eff_h;
  assign eff_w = (32'(world_w_q) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(world_w_q);
  assign eff_h = (32'(world_h_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(world_h_q);

  // captured request
  cpbe_pkg::action_e    act_q;
  logic signed [CW-1:0] sx_q, sy_q, w_q, h_q, dx_q, dy_q;
  logic [7:0]           key_q, rstart_q, shift_q, pin_q;
  logic [8:0]           rlast_q;
  logic                 rej_q;

  // one rectangle clip, selected corner
  logic                 clip_dst;
  logic signed [CW-1:0] cx, cy, nx, ny, nw, nh, tw, th;
  logic                 c_rej;
  assign clip_dst = ctl_i.clip_dst;
  assign cx = clip_dst ? dx_q : sx_q;
  assign cy = clip_dst ? dy_q : sy_q;
  always_comb begin
    nx = cx; ny = cy; tw = w_q; th = h_q;
    c_rej = (cx >= eff_w) || (cy >= eff_h);
    if (cx < 0) begin tw = w_q + cx; nx = '0; end
    if (cy < 0) begin th = h_q + cy; ny = '0; end
    nw = (nx + tw > eff_w) ? eff_w - nx : tw;
    nh = (ny + th > eff_h) ? eff_h - ny : th;
    if (nw <= 0 || nh <= 0) c_rej = 1'b1;
  end

  logic is_copy;
  assign is_copy = (act_q == cpbe_pkg::ACT_COPY);

  // cursors
  logic [XW-1:0] xo_q;
  logic [YW-1:0] yo_q;
  logic [AW-1:0] src_a, dst_a;
  assign src_a = {YW'(sy_q) + yo_q, XW'(sx_q) + xo_q};
  assign dst_a = {YW'(dy_q) + yo_q, XW'(dx_q) + xo_q};

  // frame store
  logic [7:0] mem [2**AW];
  logic [7:0] rdata_q, s_q, new_pix;
  logic       mem_we;
  logic       mem_re;
  logic [AW-1:0] wa, ra;
  assign ra = ctl_i.rd_dst ? dst_a : ctl_i.point ? {YW'(sy_q), XW'(sx_q)} : src_a;
  assign wa = ctl_i.point ? {YW'(sy_q), XW'(sx_q)} : (is_copy ? dst_a : src_a);
  // read data holds between issue and use
  assign mem_re = ctl_i.rd_src || ctl_i.rd_dst || ctl_i.point;

  always_comb begin
    new_pix = rdata_q;
    mem_we  = 1'b0;
    if (ctl_i.point) begin
      new_pix = pin_q;
      mem_we  = (act_q == cpbe_pkg::ACT_WRITE);
    end else if (ctl_i.wr) begin
      if (is_copy) begin
        new_pix = (s_q & cpbe_pkg::HI_MASK) | (rdata_q & cpbe_pkg::LO_MASK);
        mem_we  = (s_q != key_q);
      end else begin
        new_pix = rdata_q + shift_q;
        mem_we  = (rdata_q >= rstart_q) && ({1'b0, rdata_q} < rlast_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wa] <= new_pix;
    if (mem_re) rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      act_q    <= cpbe_pkg::action_e'(action_i);
      sx_q     <= CW'(src_x_i);  sy_q <= CW'(src_y_i);
      w_q      <= CW'(width_i);  h_q  <= CW'(height_i);
      dx_q     <= CW'(dst_x_i);  dy_q <= CW'(dst_y_i);
      key_q    <= key_color_i;
      rstart_q <= range_start_i;
      rlast_q  <= ({1'b0, range_start_i} + range_count_i > 9'd256) ? 9'd256
                : 9'({1'b0, range_start_i} + range_count_i);
      shift_q  <= remap_to_i - range_start_i;
      pin_q    <= pixel_in_i;
      rej_q    <= 1'b0;
      xo_q     <= '0;
      yo_q     <= '0;
    end
    if (ctl_i.clip_src) begin
      if (act_q == cpbe_pkg::ACT_WRITE || act_q == cpbe_pkg::ACT_READ) begin
        rej_q <= (sx_q >= eff_w) || (sy_q >= eff_h);
        if (sx_q < 0) sx_q <= '0;
        if (sy_q < 0) sy_q <= '0;
        w_q <= CW'(1); h_q <= CW'(1);
      end else begin
        rej_q <= c_rej;
        sx_q <= nx; sy_q <= ny; w_q <= nw; h_q <= nh;
      end
    end
    if (ctl_i.clip_dst && is_copy && !rej_q) begin
      rej_q <= c_rej;
      dx_q <= nx; dy_q <= ny; w_q <= nw; h_q <= nh;
    end
    if (ctl_i.rd_dst) s_q <= rdata_q;
    if (ctl_i.wr) begin
      if (32'(xo_q) == 32'(w_q) - 1) begin
        xo_q <= '0;
        yo_q <= yo_q + 1'b1;
      end else begin
        xo_q <= xo_q + 1'b1;
      end
    end
  end

  // destination clip result is seen in the same cycle it is computed
  assign sts_o.reject   = rej_q || (ctl_i.clip_dst && is_copy && c_rej);
  assign sts_o.is_copy  = is_copy;
  assign sts_o.is_point = (act_q == cpbe_pkg::ACT_WRITE) || (act_q == cpbe_pkg::ACT_READ);
  assign sts_o.last     = (32'(xo_q) == 32'(w_q) - 1) && (32'(yo_q) == 32'(h_q) - 1);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else         result_valid_o <= ctl_i.done;
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.done) begin
      status_o      <= rej_q;
      pixel_value_o <= (!rej_q && act_q == cpbe_pkg::ACT_READ) ? rdata_q : 8'd0;
      done_width_o  <= rej_q ? 11'd0 : 11'(w_q);
      done_height_o <= rej_q ? 11'd0 : 11'(h_q);
    end
  end

endmodule

>>> test/clipped_palette_blit_engine_tb.sv
// ----------------------------------------------------------------------------
// clipped_palette_blit_engine_tb
// Self-checking bench for the blit engine. It drives point, copy and remap
// requests under several world sizes and keeps a shadow copy of the frame
// store. Every result strobe is checked field by field against the shadow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clipped_palette_blit_engine_tb;

  localparam int MAXW     = 1024;
  localparam int MAXH     = 1024;
  localparam int WDOG_MAX = 20000;
  localparam int SEED_DIM = 8;     // side of the pre-written corner

  // One request as the block sees it.
  typedef struct {
    cpbe_pkg::action_e  act;
    logic signed [11:0] sx, sy, w, h, dx, dy;
    logic [7:0]         key, rs;
    logic [8:0]         rc;
    logic [7:0]         rto, pin;
  } blit_req_t;

  typedef struct {
    logic        status;
    logic [7:0]  pix;
    logic [10:0] dw, dh;
  } blit_res_t;

  // Directed row: the expected result is typed in only where obvious.
  typedef struct {
    blit_req_t req;
    bit        has_exp;
    blit_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic cfg_index = cpbe_pkg::CFG_WORLD_W;
  logic [10:0] cfg_data = '0;
  blit_req_t drv;
  logic result_valid, status;
  logic [7:0] pixel_value;
  logic [10:0] done_width, done_height;

  // Shadow of the frame store; an entry exists only once written.
  logic [7:0] shadow_px [int];
  int shadow_ww = 640, shadow_wh = 480;
  blit_res_t pending_res [$];

  int n_req = 0, n_res = 0, n_fail = 0, n_rej = 0;
  int wdog = 0;
  int send_idle_pct = 0;

  clipped_palette_blit_engine #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .action_i(drv.act), .src_x_i(drv.sx), .src_y_i(drv.sy),
    .width_i(drv.w), .height_i(drv.h), .dst_x_i(drv.dx), .dst_y_i(drv.dy),
    .key_color_i(drv.key), .range_start_i(drv.rs), .range_count_i(drv.rc),
    .remap_to_i(drv.rto), .pixel_in_i(drv.pin),
    .result_valid_o(result_valid), .status_o(status),
    .pixel_value_o(pixel_value), .done_width_o(done_width),
    .done_height_o(done_height)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- shadow
  function automatic int eff_ww();
    return (shadow_ww > MAXW) ? MAXW : shadow_ww;
  endfunction

  function automatic int eff_wh();
    return (shadow_wh > MAXH) ? MAXH : shadow_wh;
  endfunction

  function automatic int px_addr(int x, int y);
    return y * MAXW + x;
  endfunction

  function automatic bit clip_point(inout int x, inout int y);
    if (x >= eff_ww() || y >= eff_wh()) return 1'b0;
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    return 1'b1;
  endfunction

  // Moves only its own corner; width/height are cut in place.
  function automatic bit clip_rect(inout int x, inout int y, inout int w, inout int h);
    if (x >= eff_ww() || y >= eff_wh()) return 1'b0;
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x + w > eff_ww()) w = eff_ww() - x;
    if (y + h > eff_wh()) h = eff_wh() - y;
    return (w > 0) && (h > 0);
  endfunction

  function automatic bit area_written(int x, int y, int w, int h);
    for (int j = 0; j < h; j++)
      for (int i = 0; i < w; i++)
        if (!shadow_px.exists(px_addr(x + i, y + j))) return 1'b0;
    return 1'b1;
  endfunction

  // True when the request would read a store entry never written.
  function automatic bit reads_unwritten(blit_req_t r);
    int sx = r.sx, sy = r.sy, w = r.w, h = r.h, dx = r.dx, dy = r.dy;
    case (r.act)
      cpbe_pkg::ACT_WRITE: return 1'b0;
      cpbe_pkg::ACT_READ: begin
        if (!clip_point(sx, sy)) return 1'b0;
        return !shadow_px.exists(px_addr(sx, sy));
      end
      cpbe_pkg::ACT_COPY: begin
        if (!clip_rect(sx, sy, w, h)) return 1'b0;
        if (!clip_rect(dx, dy, w, h)) return 1'b0;
        return !(area_written(sx, sy, w, h) && area_written(dx, dy, w, h));
      end
      default: begin
        if (!clip_rect(sx, sy, w, h)) return 1'b0;
        return !area_written(sx, sy, w, h);
      end
    endcase
  endfunction

  // Applies one request to the shadow store and returns its result.
  function automatic blit_res_t blit_apply(blit_req_t r);
    blit_res_t o;
    int sx = r.sx, sy = r.sy, w = r.w, h = r.h, dx = r.dx, dy = r.dy;
    int shift, p, da;
    logic [7:0] s;
    bit ok;
    o = '{status: 1'b1, pix: '0, dw: '0, dh: '0};
    case (r.act)
      cpbe_pkg::ACT_WRITE, cpbe_pkg::ACT_READ: begin
        ok = clip_point(sx, sy);
        if (ok) begin
          if (r.act == cpbe_pkg::ACT_WRITE) shadow_px[px_addr(sx, sy)] = r.pin;
          else o.pix = shadow_px[px_addr(sx, sy)];
          w = 1;
          h = 1;
        end
      end
      cpbe_pkg::ACT_COPY: begin
        ok = clip_rect(sx, sy, w, h) && clip_rect(dx, dy, w, h);
        if (ok)
          for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++) begin
              s  = shadow_px[px_addr(sx + i, sy + j)];
              da = px_addr(dx + i, dy + j);
              if (s != r.key)
                shadow_px[da] = (s & cpbe_pkg::HI_MASK) | (shadow_px[da] & cpbe_pkg::LO_MASK);
            end
      end
      default: begin
        ok = clip_rect(sx, sy, w, h);
        shift = (int'(r.rto) - int'(r.rs) + 256) & 255;
        if (ok)
          for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++) begin
              p = shadow_px[px_addr(sx + i, sy + j)];
              if (p >= r.rs && p < int'(r.rs) + int'(r.rc))
                shadow_px[px_addr(sx + i, sy + j)] = 8'((p + shift) & 255);
            end
      end
    endcase
    if (ok) begin
      o.status = 1'b0;
      o.dw = 11'(w);
      o.dh = 11'(h);
    end
    return o;
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic blit_req_t mk_req(cpbe_pkg::action_e a, int sx, int sy, int w, int h,
                                       int dx, int dy, int key, int rs, int rc,
                                       int rto, int pin);
    blit_req_t r;
    r.act = a;
    r.sx = 12'(sx); r.sy = 12'(sy); r.w = 12'(w); r.h = 12'(h);
    r.dx = 12'(dx); r.dy = 12'(dy);
    r.key = 8'(key); r.rs = 8'(rs); r.rc = 9'(rc); r.rto = 8'(rto); r.pin = 8'(pin);
    return r;
  endfunction

  // Mostly near the written corner; now and then any 12-bit value.
  function automatic int rnd_coord();
    if ($urandom_range(7) == 0) return int'($signed(12'($urandom)));
    return int'($urandom_range(0, 16)) - 4;
  endfunction

  function automatic int rnd_size();
    if ($urandom_range(7) == 0) return int'($signed(12'($urandom)));
    return int'($urandom_range(0, 12)) - 2;
  endfunction

  function automatic blit_req_t rnd_req();
    blit_req_t r;
    int a, cx, cy;
    for (int tries = 0; tries < 60; tries++) begin
      r = mk_req(cpbe_pkg::action_e'($urandom_range(3)), rnd_coord(), rnd_coord(),
                 rnd_size(), rnd_size(), rnd_coord(), rnd_coord(), $urandom, $urandom,
                 $urandom_range(256), $urandom, $urandom);
      // pull key / range onto a real pixel so skips and hits happen
      cx = (r.sx < 0) ? 0 : int'(r.sx);
      cy = (r.sy < 0) ? 0 : int'(r.sy);
      a  = px_addr(cx, cy);
      if (cx < MAXW && cy < MAXH && shadow_px.exists(a) && $urandom_range(2) == 0) begin
        r.key = shadow_px[a];
        r.rs  = shadow_px[a] - 8'($urandom_range(3));
      end
      case ($urandom_range(5))
        0: r.rc = 9'd0;
        1: r.rc = 9'd256;
        default: ;
      endcase
      if (!reads_unwritten(r)) return r;
    end
    return mk_req(cpbe_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, $urandom);
  endfunction

  // Drives one request and queues its expected result.
  task automatic send_req(blit_req_t r, bit has_exp = 1'b0, blit_res_t exp_res = '{default: '0});
    blit_res_t pred;
    if ($urandom_range(99) < send_idle_pct) repeat ($urandom_range(1, 4)) @(negedge clk);
    while (busy) @(negedge clk);
    drv   = r;
    start = 1'b1;
    pred  = blit_apply(r);
    pending_res.push_back(has_exp ? exp_res : pred);
    if (pred.status) n_rej++;
    n_req++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Register writes only while the engine is idle.
  task automatic set_world(int w, int h);
    wait (pending_res.size() == 0);
    @(negedge clk);
    while (busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1; cfg_index = cpbe_pkg::CFG_WORLD_W; cfg_data = 11'(w);
    @(negedge clk);
    cfg_index = cpbe_pkg::CFG_WORLD_H; cfg_data = 11'(h);
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_ww = w & 11'h7ff;
    shadow_wh = h & 11'h7ff;
  endtask

  // -------------------------------------------------------------- checking
  task automatic report_mismatch(string what, int exp_v, int got_v);
    n_fail++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    blit_res_t e;
    if (rst_n && result_valid) begin
      n_res++;
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        e = pending_res.pop_front();
        if (status !== e.status) report_mismatch("status", e.status, status);
        if (pixel_value !== e.pix) report_mismatch("pixel_value", e.pix, pixel_value);
        if (done_width !== e.dw) report_mismatch("done_width", e.dw, done_width);
        if (done_height !== e.dh) report_mismatch("done_height", e.dh, done_height);
      end
    end
  end

  // Watchdog: counts cycles with neither an accepted request nor a result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired with %0d results outstanding", pending_res.size());
      $display("clipped_palette_blit_engine_tb: FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------ main flow
  dir_row_t dir_rows [$];

  function automatic blit_res_t res_of(int st, int pix, int dw, int dh);
    blit_res_t o;
    o.status = st[0]; o.pix = 8'(pix); o.dw = 11'(dw); o.dh = 11'(dh);
    return o;
  endfunction

  initial begin
    blit_res_t ok11, rej;
    int worlds_w [7] = '{8, 16, 1, 0, 2047, 1024, 640};
    int worlds_h [7] = '{8, 12, 1, 5, 2047, 1024, 480};

    drv = mk_req(cpbe_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    ok11 = res_of(0, 0, 1, 1);
    rej  = res_of(1, 0, 0, 0);
    // Directed part at the reset world of 640 x 480.
    // most negative point clamps to the origin
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_WRITE, -2048, -2048, 0, 0, 0, 0, 0, 0, 0, 0,
                                8'hff), 1, ok11});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         1, res_of(0, 255, 1, 1)});
    // far corner of the world
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_WRITE, 639, 479, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00),
                         1, ok11});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_READ, 639, 479, -1, -1, -1, -1, 255, 255, 256,
                                255, 255), 1, ok11});
    // just past the edge on each axis
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_WRITE, 640, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h5a),
                         1, rej});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_READ, 0, 480, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, rej});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_COPY, 2047, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0), 1, rej});
    // negative size, and a negative corner that eats the whole width
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_REMAP, 0, 0, -2048, 1, 0, 0, 0, 0, 1, 1, 0),
                         1, rej});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_REMAP, -3, 0, 3, 1, 0, 0, 0, 0, 1, 1, 0), 1, rej});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_COPY, 0, 0, 1, 1, 639, 479, 8'h0f, 0, 0, 0, 0),
                         0, rej});
    // oversized rectangle cut at the far edge
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_REMAP, 639, 479, 2047, 2047, 0, 0, 0, 0, 256, 5,
                                0), 1, ok11});
    // empty range still reports its size
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_REMAP, -5, 0, 6, 1, 0, 0, 0, 8'hff, 0, 0, 0),
                         1, ok11});
    // range running past index 255
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_REMAP, 0, 0, 1, 1, 0, 0, 0, 250, 256, 3, 0),
                         0, rej});
    // key equal to the source pixel: nothing moves
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_COPY, 639, 479, 1, 1, 0, 0, 8'hf5, 0, 0, 0, 0),
                         0, rej});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, rej});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_COPY, 0, 0, 1, 1, 639, 479, 8'h0e, 0, 0, 0, 0),
                         0, rej});
    dir_rows.push_back('{mk_req(cpbe_pkg::ACT_READ, 639, 479, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         0, rej});
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].res);

    // Seed a small corner so reads, copies and remaps only see written pixels.
    set_world(SEED_DIM, SEED_DIM);
    for (int y = 0; y < SEED_DIM; y++)
      for (int x = 0; x < SEED_DIM; x++)
        send_req(mk_req(cpbe_pkg::ACT_WRITE, x, y, 0, 0, 0, 0, 0, 0, 0, 0, $urandom));

    // Random part: each world setting under each idle pattern.
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 35 : (m == 1) ? 73 : 0;
      foreach (worlds_w[k]) begin
        set_world(worlds_w[k], worlds_h[k]);
        repeat (3) send_req(rnd_req());
      end
    end

    wait (pending_res.size() == 0);
    repeat (50) @(negedge clk);
    $display("covered %0d requests (%0d clipped away) and %0d results", n_req, n_rej, n_res);
    $display("world sizes from 0 up to 2047, all four commands, %0d mismatches", n_fail);
    if (n_fail == 0 && pending_res.size() == 0) begin
      $display("clipped_palette_blit_engine_tb: PASS");
    end else begin
      $display("clipped_palette_blit_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/cpbe_pkg.sv
design/cpbe_ctrl.sv
design/cpbe_datapath.sv
design/clipped_palette_blit_engine.sv
test/clipped_palette_blit_engine_tb.sv
